>>> hdl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; every macro samples on clk_i and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle implication checked at every clock edge.
`define FLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication: cond at one edge requires prop at the next.
`define FLA_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> hdl/fla_pkg.sv
// Package for the free-list block allocator: pool size, widths, codes and states.
// Depends on nothing; used by the allocator and its testbench.
`default_nettype none

package fla_pkg;

  localparam int unsigned POOL_BLOCKS = 256;
  localparam int unsigned ADDR_W      = $clog2(POOL_BLOCKS);
  localparam int unsigned LINK_W      = $clog2(POOL_BLOCKS + 1);
  localparam int unsigned BLK_W       = 8;
  localparam int unsigned CNT_W       = 9;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_BLOCKS);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } fla_state_e;

endpackage

`default_nettype wire

>>> hdl/fla_req_if.sv
// Request channel of the allocator: one word carries the function and a block index.
// Depends on nothing.
`default_nettype none

interface fla_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] ret_index;

  modport source (output valid, output func, output ret_index, input ready);
  modport sink   (input valid, input func, input ret_index, output ready);
endinterface

`default_nettype wire

>>> hdl/fla_rsp_if.sv
// Response channel of the allocator: one word carries status, granted index and count.
// Depends on nothing.
`default_nettype none

interface fla_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] granted_index;
  logic [8:0] free_count;

  modport source (output valid, output status, output granted_index, output free_count,
                  input ready);
  modport sink   (input valid, input status, input granted_index, input free_count,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/fla_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module fla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/free_list_block_allocator.sv
// Free-list block allocator: a free or failed allocation ends in S_IDLE; a grant needs
// S_READ, as the link RAM gives the head's next link in the cycle after its address.
// A word is accepted in the idle state while the response register is empty or drained.
// For a free or failed allocation the response register is loaded on acceptance; for a
// granted block it is loaded in S_READ, after the link read.
// Reset clears the per-entry valid bits at once; an unwritten entry reads as i+1.
`default_nettype none

module free_list_block_allocator
  import fla_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  fla_req_if.sink      req_i,
  fla_rsp_if.source    rsp_o
);

  `include "assert_macros.svh"

  fla_state_e              st_q, st_d;
  logic [LINK_W-1:0]       head_q, head_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [POOL_BLOCKS-1:0]  vld_q, vld_d;
  logic                    fb_vld_q, fb_vld_d;
  logic                    rsp_vld_q, rsp_vld_d;
  logic                    status_q;
  logic [BLK_W-1:0]        grant_q;
  logic [CNT_W-1:0]        count_q;

  logic                    accept;
  logic                    head_null;
  logic                    idx_ok;
  logic [ADDR_W-1:0]       head_addr;
  logic [ADDR_W-1:0]       idx_addr;
  logic                    ram_we;
  logic                    ram_re;
  logic [LINK_W-1:0]       ram_rdata;
  logic                    res_load;
  logic                    res_status;
  logic [BLK_W-1:0]        res_grant;

  assign req_i.ready = (st_q == S_IDLE) && (!rsp_vld_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign head_null   = head_q >= LINK_NULL;
  assign idx_ok      = LINK_W'(req_i.ret_index) < LINK_W'(POOL_BLOCKS);
  assign head_addr   = head_q[ADDR_W-1:0];
  assign idx_addr    = ADDR_W'(req_i.ret_index);

  fla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_addr),
    .wdata_i (head_q),
    .re_i    (ram_re),
    .raddr_i (head_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    st_d       = st_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    vld_d      = vld_q;
    fb_vld_d   = fb_vld_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    res_load   = 1'b0;
    res_status = STATUS_OK;
    res_grant  = '0;
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.func == FUNC_FREE) begin
            res_load = 1'b1;
            if (idx_ok) begin
              ram_we          = 1'b1;
              vld_d[idx_addr] = 1'b1;
              head_d          = LINK_W'(req_i.ret_index);
              if (cnt_q < CNT_W'(POOL_BLOCKS)) begin
                cnt_d = cnt_q + 1'b1;
              end
            end
          end else if (head_null) begin
            res_load   = 1'b1;
            res_status = STATUS_NO_SPACE;
          end else begin
            ram_re   = 1'b1;
            fb_vld_d = vld_q[head_addr];
            st_d     = S_READ;
          end
        end
      end
      S_READ: begin
        res_load  = 1'b1;
        res_grant = BLK_W'(head_q);
        head_d    = fb_vld_q ? ram_rdata : head_q + 1'b1;
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
        st_d = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_vld_d = rsp_vld_q;
    if (res_load) begin
      rsp_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      head_q    <= '0;
      cnt_q     <= CNT_W'(POOL_BLOCKS);
      vld_q     <= '0;
      fb_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      vld_q     <= vld_d;
      fb_vld_q  <= fb_vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q <= res_status;
      grant_q  <= res_grant;
      count_q  <= cnt_d;
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.granted_index = grant_q;
  assign rsp_o.free_count    = count_q;

  `FLA_ASSERT(a_cnt_range, cnt_q <= CNT_W'(POOL_BLOCKS), "Free count exceeds the pool size.")
  `FLA_ASSERT(a_read_head, (st_q == S_READ) |-> !head_null, "Link read issued for a null head.")
  `FLA_ASSERT(a_read_slot, (st_q == S_READ) |-> !rsp_vld_q, "Response slot busy during a grant.")
  `FLA_ASSERT_NEXT(a_alloc_read, accept && (req_i.func == FUNC_ALLOC) && !head_null,
    st_q == S_READ, "Allocation with a free head did not start a link read.")

endmodule

`default_nettype wire

>>> verif/free_list_block_allocator_tb.sv
// Self-checking testbench for free_list_block_allocator with randomized request and response pacing.
// Depends on fla_pkg, fla_req_if and fla_rsp_if and on the allocator RTL itself.
// A local model of the linked free list predicts each response word in order.
`timescale 1ns / 100ps

module free_list_block_allocator_tb;
  import fla_pkg::*;

  typedef struct packed {
    logic             func;
    logic [BLK_W-1:0] ret_index;
  } req_word_t;

  typedef struct packed {
    logic             status;
    logic [BLK_W-1:0] granted_index;
    logic [CNT_W-1:0] free_count;
  } rsp_word_t;

  typedef struct packed {
    logic [POOL_BLOCKS-1:0][LINK_W-1:0] link;
    logic [LINK_W-1:0]                  head;
    logic [CNT_W-1:0]                   total;
  } pool_t;

  logic clk_i;
  logic rst_ni;

  fla_req_if req_if();
  fla_rsp_if rsp_if();

  free_list_block_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  req_word_t   req_q[$];
  rsp_word_t   rsp_due_q[$];
  logic [7:0]  held_q[$];
  pool_t       gen_pool;
  pool_t       chk_pool;
  int unsigned errors = 0;
  bit          req_fired;
  bit          rsp_fired;
  bit          src_burst;
  bit          snk_burst;
  int unsigned src_wait;
  int unsigned snk_wait;

  always #6 clk_i = ~clk_i;

  function automatic void pool_reset(output pool_t p);
    int i;
    for (i = 0; i < POOL_BLOCKS; i++) begin
      p.link[i] = LINK_W'(i + 1);
    end
    p.head  = '0;
    p.total = CNT_W'(POOL_BLOCKS);
  endfunction

  function automatic void pool_step(inout pool_t p, input req_word_t w, output rsp_word_t r);
    r.status        = STATUS_OK;
    r.granted_index = '0;
    if (w.func == FUNC_ALLOC) begin
      if (p.head == LINK_NULL) begin
        r.status = STATUS_NO_SPACE;
      end else begin
        r.granted_index = p.head[BLK_W-1:0];
        p.head = p.link[p.head[BLK_W-1:0]];
        if (p.total != 0) p.total = p.total - 1'b1;
      end
    end else begin
      p.link[w.ret_index] = p.head;
      p.head = LINK_W'(w.ret_index);
      if (p.total < CNT_W'(POOL_BLOCKS)) p.total = p.total + 1'b1;
    end
    r.free_count = p.total;
  endfunction

  task automatic report(input string msg);
    errors++;
    $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  function automatic req_word_t alloc_word();
    return '{func: FUNC_ALLOC, ret_index: BLK_W'($urandom)};
  endfunction

  function automatic req_word_t free_word(input logic [BLK_W-1:0] idx);
    return '{func: FUNC_FREE, ret_index: idx};
  endfunction

  function automatic void enqueue(input req_word_t w);
    rsp_word_t r;
    int        hits[$];
    pool_step(gen_pool, w, r);
    if (w.func == FUNC_ALLOC) begin
      if (r.status == STATUS_OK) held_q.push_back(r.granted_index);
    end else begin
      hits = held_q.find_first_index(x) with (x == w.ret_index);
      if (hits.size() != 0) held_q.delete(hits[0]);
    end
    req_q.push_back(w);
  endfunction

  function automatic void free_some_held();
    int unsigned k;
    if (held_q.size() == 0) begin
      enqueue(alloc_word());
    end else begin
      k = $urandom_range(0, held_q.size() - 1);
      enqueue(free_word(held_q[k]));
    end
  endfunction

  function automatic void mixed_run(input int unsigned n);
    int unsigned left;
    int unsigned pct;
    left = 0;
    pct  = 50;
    repeat (n) begin
      if (left == 0) begin
        left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: begin
            pct = 15;
          end
          1: begin
            pct = 50;
          end
          default: begin
            pct = 85;
          end
        endcase
      end
      left--;
      if ($urandom_range(0, 99) < pct) enqueue(alloc_word());
      else free_some_held();
    end
  endfunction

  always @(negedge clk_i) begin : source
    req_word_t w;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fired) begin
      if (src_wait != 0) begin
        req_if.valid <= 1'b0;
        src_wait     <= src_wait - 1;
      end else if (req_q.size() != 0) begin
        w = req_q.pop_front();
        req_if.valid     <= 1'b1;
        req_if.func      <= w.func;
        req_if.ret_index <= w.ret_index;
        if ($urandom_range(0, 39) == 0) src_burst <= !src_burst;
        src_wait <= src_burst ? 0 : $urandom_range(0, 7);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : sink
    int unsigned stall;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      stall = snk_wait;
      if (rsp_fired) begin
        if ($urandom_range(0, 39) == 0) snk_burst <= !snk_burst;
        stall = snk_burst ? 0 : $urandom_range(0, 7);
      end
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        snk_wait     <= stall - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        snk_wait     <= 0;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    rsp_word_t seen;
    rsp_word_t due;
    req_word_t w;
    if (!rst_ni) begin
      req_fired <= 1'b0;
      rsp_fired <= 1'b0;
    end else begin
      req_fired <= req_if.valid && req_if.ready;
      rsp_fired <= rsp_if.valid && rsp_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        seen = '{status: rsp_if.status, granted_index: rsp_if.granted_index,
                 free_count: rsp_if.free_count};
        if (rsp_due_q.size() == 0) begin
          report($sformatf("unexpected response word %h", seen));
        end else begin
          due = rsp_due_q.pop_front();
          if (seen.status != due.status)
            report($sformatf("status %h, expected %h", seen.status, due.status));
          if (seen.granted_index != due.granted_index)
            report($sformatf("granted_index %h, expected %h",
                             seen.granted_index, due.granted_index));
          if (seen.free_count != due.free_count)
            report($sformatf("free_count %0d, expected %0d",
                             seen.free_count, due.free_count));
        end
      end
      if (req_if.valid && req_if.ready) begin
        w = '{func: req_if.func, ret_index: req_if.ret_index};
        pool_step(chk_pool, w, due);
        rsp_due_q.push_back(due);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL free_list_block_allocator");
    $finish;
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.func      = FUNC_ALLOC;
    req_if.ret_index = '0;
    rsp_if.ready     = 1'b0;
    pool_reset(gen_pool);
    pool_reset(chk_pool);

    // Opening sequence: grants from a fresh list, frees and regrants of low blocks.
    enqueue('{func: FUNC_ALLOC, ret_index: 8'hFF});
    enqueue('{func: FUNC_ALLOC, ret_index: 8'h00});
    enqueue(alloc_word());
    enqueue(free_word(8'd1));
    enqueue(alloc_word());
    enqueue(free_word(8'd0));
    enqueue(free_word(8'd2));
    enqueue(free_word(8'd1));
    repeat (3) enqueue(alloc_word());

    mixed_run(500);

    // Drain the pool completely, ask for more than it holds, then free every held block.
    while (gen_pool.head != LINK_NULL) enqueue(alloc_word());
    repeat (4) enqueue(alloc_word());
    while (held_q.size() != 0) free_some_held();

    mixed_run(200);
    while (held_q.size() != 0) free_some_held();

    // With the pool full, freeing again saturates the count and closes a loop
    // in the list, so later grants continue after the count has reached zero.
    enqueue(free_word(8'hFF));
    enqueue(free_word(8'h80));
    repeat (280) enqueue(alloc_word());
    repeat (100) enqueue('{func: 1'($urandom), ret_index: BLK_W'($urandom)});

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || req_if.valid) @(posedge clk_i);
    @(posedge clk_i);
    while (rsp_due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);

    if (errors == 0) begin
      $display("PASS free_list_block_allocator");
    end else begin
      $display("FAIL free_list_block_allocator");
    end
    $finish;
  end

endmodule
